// ===== rtl/phpu_pkg.sv =====
// ----------------------------------------------------------------------------
// phpu_pkg
// Shared widths, constants, types and helpers of the particle heading and
// position update pipeline.
// ----------------------------------------------------------------------------
package phpu_pkg;

  localparam int POS_W      = 24;
  localparam int FRAC_BITS  = 12;
  localparam int ANG_W      = 16;
  localparam int CNT_W      = 12;
  localparam int CFG_W      = 16;
  localparam int SIZE_W     = 12;
  localparam int TRIG_W     = 16;
  localparam int MAG_W      = 15;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_CELLS  = 2;
  localparam int PIPE_LAT   = 9;

  // odd polynomial coefficients, q14
  localparam logic [MAG_W-1:0] TRIG_A   = 15'd25736;
  localparam logic [MAG_W-1:0] TRIG_B   = 15'd10512;
  localparam logic [MAG_W-1:0] TRIG_C   = 15'd1160;
  localparam logic [MAG_W-1:0] Q14_ONE  = 15'd16384;

  // constant subtracted from in each horner cell, innermost first
  localparam logic [MAG_W-1:0] CELL_COEF [NUM_CELLS] = '{TRIG_B, TRIG_A};

  localparam logic [CFG_W-1:0]  RST_TURN_BASE    = 16'h8000;
  localparam logic [CFG_W-1:0]  RST_TURN_GAIN    = 16'd3095;
  localparam logic [CFG_W-1:0]  RST_STEP_SPEED   = 16'd2744;
  localparam logic [SIZE_W-1:0] RST_ARENA_WIDTH  = 12'd512;
  localparam logic [SIZE_W-1:0] RST_ARENA_HEIGHT = 12'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_BASE    = 3'd0,
    REG_TURN_GAIN    = 3'd1,
    REG_STEP_SPEED   = 3'd2,
    REG_ARENA_WIDTH  = 3'd3,
    REG_ARENA_HEIGHT = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [MAG_W-1:0] x2;
    logic [MAG_W-1:0] acc;
  } trig_lane_t;

  typedef struct packed {
    trig_lane_t       sin_l;
    trig_lane_t       cos_l;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [ANG_W-1:0] heading;
  } cell_data_t;

  // (p + 0.5) >> 14 on a non-negative product below 2^29
  function automatic logic [MAG_W:0] rnd_q14(input logic [PROD_W-1:0] prod);
    logic [PROD_W:0] s;
    s = {1'b0, prod} + (PROD_W+1)'(8192);
    return s[PROD_W-1:14];
  endfunction

endpackage

// ===== rtl/particle_heading_position_update_top.sv =====
// ----------------------------------------------------------------------------
// particle_heading_position_update_top
// Turns a particle's heading by its neighbor counts, evaluates sine and cosine
// through a row of horner cells and moves it one step on the torus.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while busy is low, set by the 9-stage pipeline with
//   the two-cell horner chain in its middle
// reset: synchronous, clears the valid pipe and reloads the registers;
//   busy is high in reset and for the cycle after reset is released, low otherwise
// results are never held back, the receiver takes each out_valid strobe
module particle_heading_position_update_top import phpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [ANG_W-1:0]     in_heading,
  input  logic [CNT_W-1:0]     in_near_count,
  input  logic [CNT_W-1:0]     in_left_count,
  input  logic [CNT_W-1:0]     in_right_count,
  output logic                 out_valid,
  output logic [POS_W-1:0]     out_new_x,
  output logic [POS_W-1:0]     out_new_y,
  output logic [ANG_W-1:0]     out_new_heading,
  output logic [TRIG_W-1:0]    out_sine,
  output logic [TRIG_W-1:0]    out_cosine,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int TURN_W = CFG_W + CNT_W + 1;

  // configuration
  logic [CFG_W-1:0]  turn_base_r;
  logic [CFG_W-1:0]  turn_gain_r;
  logic [CFG_W-1:0]  step_speed_r;
  logic [SIZE_W-1:0] arena_width_r;
  logic [SIZE_W-1:0] arena_height_r;

  logic                 busy_r;
  logic                 accept;
  logic [PIPE_LAT-1:0]  vld_r;
  logic [PIPE_LAT-1:0]  vld_nxt;

  // stage 1
  logic [POS_W-1:0]  s1_pos_x_r;
  logic [POS_W-1:0]  s1_pos_y_r;
  logic [ANG_W-1:0]  s1_heading_r;
  logic [ANG_W-1:0]  s1_turn_r;
  logic              s1_up_r;
  logic              s1_down_r;
  logic [TURN_W-1:0] turn_prod;

  // stage 2
  logic [ANG_W-1:0]  turn_sel;
  logic [ANG_W-1:0]  head_nxt;
  logic [ANG_W-1:0]  s2_heading_r;
  logic [POS_W-1:0]  s2_pos_x_r;
  logic [POS_W-1:0]  s2_pos_y_r;
  trig_lane_t        s2_sin_r;
  trig_lane_t        s2_cos_r;

  // stage 3 and the horner chain
  cell_data_t        s3_nxt;
  cell_data_t        s3_r;
  cell_data_t        chain [NUM_CELLS+1];

  // stage 6
  logic [TRIG_W-1:0] s6_sine_r;
  logic [TRIG_W-1:0] s6_cosine_r;
  logic [POS_W-1:0]  s6_pos_x_r;
  logic [POS_W-1:0]  s6_pos_y_r;
  logic [ANG_W-1:0]  s6_heading_r;

  // delay of the side fields alongside the move units
  logic [ANG_W-1:0]  dly_heading_r [3];
  logic [TRIG_W-1:0] dly_sine_r    [3];
  logic [TRIG_W-1:0] dly_cosine_r  [3];

  function automatic trig_lane_t fold_angle(input logic [ANG_W-1:0] t);
    trig_lane_t lane;
    logic [MAG_W-1:0] low;
    low = {1'b0, t[13:0]};
    lane.mag = t[14] ? Q14_ONE - low : low;
    lane.neg = t[15];
    lane.x2  = '0;
    lane.acc = '0;
    return lane;
  endfunction

  function automatic logic [TRIG_W-1:0] finish_lane(input trig_lane_t lane);
    logic [MAG_W:0]    r;
    logic [MAG_W-1:0]  rc;
    logic [TRIG_W-1:0] v;
    r  = rnd_q14(lane.mag * lane.acc);
    rc = (r > {1'b0, Q14_ONE}) ? Q14_ONE : r[MAG_W-1:0];
    v  = {1'b0, rc};
    return lane.neg ? -v : v;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration and control
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_base_r    <= RST_TURN_BASE;
      turn_gain_r    <= RST_TURN_GAIN;
      step_speed_r   <= RST_STEP_SPEED;
      arena_width_r  <= RST_ARENA_WIDTH;
      arena_height_r <= RST_ARENA_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_TURN_BASE:    turn_base_r    <= cfg_wdata;
        REG_TURN_GAIN:    turn_gain_r    <= cfg_wdata;
        REG_STEP_SPEED:   step_speed_r   <= cfg_wdata;
        REG_ARENA_WIDTH:  arena_width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_ARENA_HEIGHT: arena_height_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept  = start && !busy_r;
  assign vld_nxt = {vld_r[PIPE_LAT-2:0], accept};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= vld_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: turn product
  // ---------------------------------------------------------------------------
  assign turn_prod = TURN_W'($signed(turn_gain_r) * $signed({1'b0, in_near_count}));

  always_ff @(posedge clk) begin
    s1_pos_x_r   <= in_pos_x;
    s1_pos_y_r   <= in_pos_y;
    s1_heading_r <= in_heading;
    s1_turn_r    <= turn_prod[ANG_W-1:0];
    s1_up_r      <= in_right_count > in_left_count;
    s1_down_r    <= in_right_count < in_left_count;
  end

  // ---------------------------------------------------------------------------
  // stage 2: new heading, fold to quarter-turn magnitudes
  // ---------------------------------------------------------------------------
  always_comb begin
    if (s1_up_r) begin
      turn_sel = s1_turn_r;
    end else if (s1_down_r) begin
      turn_sel = -s1_turn_r;
    end else begin
      turn_sel = '0;
    end
    // full turn is 2^16, so the wrap is plain overflow
    head_nxt = s1_heading_r + turn_base_r + turn_sel;
  end

  always_ff @(posedge clk) begin
    s2_heading_r <= head_nxt;
    s2_pos_x_r   <= s1_pos_x_r;
    s2_pos_y_r   <= s1_pos_y_r;
    s2_sin_r     <= fold_angle(head_nxt);
    s2_cos_r     <= fold_angle(head_nxt + ANG_W'(16384));
  end

  // ---------------------------------------------------------------------------
  // stage 3: square, then the horner cells
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [MAG_W:0] sq_sin;
    logic [MAG_W:0] sq_cos;
    sq_sin = rnd_q14(s2_sin_r.mag * s2_sin_r.mag);
    sq_cos = rnd_q14(s2_cos_r.mag * s2_cos_r.mag);
    s3_nxt.sin_l     = s2_sin_r;
    s3_nxt.sin_l.x2  = sq_sin[MAG_W-1:0];
    s3_nxt.sin_l.acc = TRIG_C;
    s3_nxt.cos_l     = s2_cos_r;
    s3_nxt.cos_l.x2  = sq_cos[MAG_W-1:0];
    s3_nxt.cos_l.acc = TRIG_C;
    s3_nxt.pos_x     = s2_pos_x_r;
    s3_nxt.pos_y     = s2_pos_y_r;
    s3_nxt.heading   = s2_heading_r;
  end

  always_ff @(posedge clk) begin
    s3_r <= s3_nxt;
  end

  assign chain[0] = s3_r;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    phpu_horner_cell u_cell (
      .clk      (clk),
      .cell_in  (chain[i]),
      .coef     (CELL_COEF[i]),
      .cell_out (chain[i+1])
    );
  end

  // ---------------------------------------------------------------------------
  // stage 6: last multiply, clamp and sign
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    s6_sine_r    <= finish_lane(chain[NUM_CELLS].sin_l);
    s6_cosine_r  <= finish_lane(chain[NUM_CELLS].cos_l);
    s6_pos_x_r   <= chain[NUM_CELLS].pos_x;
    s6_pos_y_r   <= chain[NUM_CELLS].pos_y;
    s6_heading_r <= chain[NUM_CELLS].heading;
  end

  // ---------------------------------------------------------------------------
  // stages 7 to 9: move and wrap
  // ---------------------------------------------------------------------------
  phpu_move_axis u_move_x (
    .clk     (clk),
    .trig    (s6_cosine_r),
    .pos     (s6_pos_x_r),
    .speed   (step_speed_r),
    .size    (arena_width_r),
    .new_pos (out_new_x)
  );

  phpu_move_axis u_move_y (
    .clk     (clk),
    .trig    (s6_sine_r),
    .pos     (s6_pos_y_r),
    .speed   (step_speed_r),
    .size    (arena_height_r),
    .new_pos (out_new_y)
  );

  always_ff @(posedge clk) begin
    dly_heading_r[0] <= s6_heading_r;
    dly_sine_r[0]    <= s6_sine_r;
    dly_cosine_r[0]  <= s6_cosine_r;
    for (int k = 1; k < 3; k++) begin
      dly_heading_r[k] <= dly_heading_r[k-1];
      dly_sine_r[k]    <= dly_sine_r[k-1];
      dly_cosine_r[k]  <= dly_cosine_r[k-1];
    end
  end

  assign busy            = busy_r;
  assign out_valid       = vld_r[PIPE_LAT-1];
  assign out_new_heading = dly_heading_r[2];
  assign out_sine        = dly_sine_r[2];
  assign out_cosine      = dly_cosine_r[2];

endmodule

// ===== rtl/phpu_horner_cell.sv =====
// ----------------------------------------------------------------------------
// phpu_horner_cell
// One horner step for the sine and cosine lanes: acc <= coef - rnd(x2 * acc).
// The particle data rides along to the next cell.
// ----------------------------------------------------------------------------
module phpu_horner_cell import phpu_pkg::*; (
  input  logic             clk,
  input  cell_data_t       cell_in,
  input  logic [MAG_W-1:0] coef,
  output cell_data_t       cell_out
);

  cell_data_t       cell_nxt;
  cell_data_t       cell_r;
  logic [MAG_W:0]   rnd_sin;
  logic [MAG_W:0]   rnd_cos;

  always_comb begin
    rnd_sin = rnd_q14(cell_in.sin_l.x2 * cell_in.sin_l.acc);
    rnd_cos = rnd_q14(cell_in.cos_l.x2 * cell_in.cos_l.acc);
    cell_nxt = cell_in;
    // results stay positive for every folded angle
    cell_nxt.sin_l.acc = coef - rnd_sin[MAG_W-1:0];
    cell_nxt.cos_l.acc = coef - rnd_cos[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cell_out = cell_r;

endmodule

// ===== rtl/phpu_move_axis.sv =====
// ----------------------------------------------------------------------------
// phpu_move_axis
// Moves one coordinate by speed times a q14 direction component and wraps it
// once on the torus. Three register stages.
// ----------------------------------------------------------------------------
module phpu_move_axis import phpu_pkg::*; (
  input  logic               clk,
  input  logic [TRIG_W-1:0]  trig,
  input  logic [POS_W-1:0]   pos,
  input  logic [CFG_W-1:0]   speed,
  input  logic [SIZE_W-1:0]  size,
  output logic [POS_W-1:0]   new_pos
);

  localparam int MUL_W = CFG_W + MAG_W;
  localparam int D_W   = MUL_W - 14;
  localparam int SUM_W = POS_W + 2;

  logic [MAG_W-1:0]        tmag;
  logic [MUL_W-1:0]        prod_r;
  logic                    neg_r;
  logic [POS_W-1:0]        pos_r;
  logic [MUL_W:0]          rnd_sum;
  logic [D_W-1:0]          delta;
  logic signed [SUM_W-1:0] p_nxt;
  logic signed [SUM_W-1:0] p_r;
  logic signed [SUM_W-1:0] ext;
  logic signed [SUM_W-1:0] wrap;
  logic [POS_W-1:0]        new_pos_r;

  always_comb begin
    logic [TRIG_W-1:0] neg_trig;
    neg_trig = -trig;
    tmag = trig[TRIG_W-1] ? neg_trig[MAG_W-1:0] : trig[MAG_W-1:0];
  end

  always_ff @(posedge clk) begin
    prod_r <= speed * tmag;
    neg_r  <= trig[TRIG_W-1];
    pos_r  <= pos;
  end

  // round half away from zero on the magnitude, sign applied afterwards
  always_comb begin
    rnd_sum = {1'b0, prod_r} + (MUL_W+1)'(8192);
    delta   = rnd_sum[MUL_W-1:14];
    if (neg_r) begin
      p_nxt = $signed({2'b00, pos_r}) - $signed({{(SUM_W-D_W){1'b0}}, delta});
    end else begin
      p_nxt = $signed({2'b00, pos_r}) + $signed({{(SUM_W-D_W){1'b0}}, delta});
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

  always_comb begin
    ext = $signed({{(SUM_W-SIZE_W-FRAC_BITS){1'b0}}, size, {FRAC_BITS{1'b0}}});
    if (p_r < 0) begin
      wrap = p_r + ext;
    end else if (p_r >= ext) begin
      wrap = p_r - ext;
    end else begin
      wrap = p_r;
    end
  end

  always_ff @(posedge clk) begin
    new_pos_r <= wrap[POS_W-1:0];
  end

  assign new_pos = new_pos_r;

endmodule

// ===== rtl/phpu_checker.sv =====
// ----------------------------------------------------------------------------
// phpu_checker
// Port-level checks of the particle update block: fixed latency, reset
// behavior and range of the trig outputs.
// ----------------------------------------------------------------------------
module phpu_checker import phpu_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic [POS_W-1:0]     in_pos_x,
  input logic [POS_W-1:0]     in_pos_y,
  input logic [ANG_W-1:0]     in_heading,
  input logic [CNT_W-1:0]     in_near_count,
  input logic [CNT_W-1:0]     in_left_count,
  input logic [CNT_W-1:0]     in_right_count,
  input logic                 out_valid,
  input logic [POS_W-1:0]     out_new_x,
  input logic [POS_W-1:0]     out_new_y,
  input logic [ANG_W-1:0]     out_new_heading,
  input logic [TRIG_W-1:0]    out_sine,
  input logic [TRIG_W-1:0]    out_cosine,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_wdata
);

  // every accepted transaction is followed by its out_valid strobe
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##9 out_valid)
    else $error("accepted transaction produced no result");

  // no result without a matching accepted transaction
  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 9))
    else $error("result without matching transaction");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && busy))
    else $error("reset did not flush the pipe");

  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_sine) >= -16'sd16384 && $signed(out_sine) <= 16'sd16384
                   && $signed(out_cosine) >= -16'sd16384
                   && $signed(out_cosine) <= 16'sd16384))
    else $error("trig output outside unit range");

endmodule

bind particle_heading_position_update_top phpu_checker u_phpu_checker (.*);

// ===== tb/particle_motion_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_motion_checker
// Watches the particle update channels, predicts the turned heading, its
// sine and cosine and the wrapped position for every accepted particle, and
// compares each result transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module particle_motion_checker import phpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic [POS_W-1:0]     in_pos_x,
  input  logic [POS_W-1:0]     in_pos_y,
  input  logic [ANG_W-1:0]     in_heading,
  input  logic [CNT_W-1:0]     in_near_count,
  input  logic [CNT_W-1:0]     in_left_count,
  input  logic [CNT_W-1:0]     in_right_count,
  input  logic                 out_valid,
  input  logic [POS_W-1:0]     out_new_x,
  input  logic [POS_W-1:0]     out_new_y,
  input  logic [ANG_W-1:0]     out_new_heading,
  input  logic [TRIG_W-1:0]    out_sine,
  input  logic [TRIG_W-1:0]    out_cosine,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending
);

  localparam int COEF_A = int'(TRIG_A);
  localparam int COEF_B = int'(TRIG_B);
  localparam int COEF_C = int'(TRIG_C);
  localparam int UNIT   = int'(Q14_ONE);

  typedef struct packed {
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [ANG_W-1:0]  hdg;
    logic [TRIG_W-1:0] sin_v;
    logic [TRIG_W-1:0] cos_v;
  } motion_t;

  motion_t motion_q[$];

  logic signed [CFG_W-1:0] turn_base_q;
  logic signed [CFG_W-1:0] turn_gain_q;
  logic [CFG_W-1:0]        step_speed_q;
  logic [SIZE_W-1:0]       arena_width_q;
  logic [SIZE_W-1:0]       arena_height_q;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // odd polynomial sine on a 16-bit turn, q14, magnitudes rounded half up
  function automatic logic [TRIG_W-1:0] q14_sine(input logic [15:0] t);
    int fold, mag, sq, inner, mid, res;
    if (t < 16'd16384) fold = int'(t);
    else if (t < 16'd49152) fold = 32768 - int'(t);
    else fold = int'(t) - 65536;
    mag   = (fold < 0) ? -fold : fold;
    sq    = (mag * mag + 8192) >>> 14;
    inner = COEF_B - ((sq * COEF_C + 8192) >>> 14);
    mid   = COEF_A - ((sq * inner + 8192) >>> 14);
    res   = (mag * mid + 8192) >>> 14;
    if (res > UNIT) res = UNIT;
    if (res < 0) res = 0;
    return TRIG_W'((fold < 0) ? -res : res);
  endfunction

  // one step along an axis, single wrap on the torus
  function automatic logic [POS_W-1:0] step_axis(input logic [POS_W-1:0] pos,
                                                 input logic signed [TRIG_W-1:0] trig,
                                                 input logic [SIZE_W-1:0] size);
    longint prod, step_len, extent, p;
    prod     = longint'(step_speed_q) * ((trig < 0) ? -longint'(trig) : longint'(trig));
    step_len = (prod + 8192) >>> 14;
    if (trig < 0) step_len = -step_len;
    extent   = longint'(size) << FRAC_BITS;
    p        = longint'(pos) + step_len;
    if (p < 0) p = p + extent;
    else if (p >= extent) p = p - extent;
    return POS_W'(p);
  endfunction

  function automatic motion_t predict_motion(input logic [POS_W-1:0] x, y,
                                             input logic [ANG_W-1:0] h,
                                             input logic [CNT_W-1:0] n, l, r);
    motion_t m;
    int      dir;
    int      turn;
    dir     = (r > l) ? 1 : ((r < l) ? -1 : 0);
    turn    = int'(turn_gain_q) * int'(n) * dir;
    m.hdg   = ANG_W'(int'(h) + int'(turn_base_q) + turn);
    m.sin_v = q14_sine(m.hdg);
    m.cos_v = q14_sine(16'(m.hdg + 16'd16384));
    m.x     = step_axis(x, m.cos_v, arena_width_q);
    m.y     = step_axis(y, m.sin_v, arena_height_q);
    return m;
  endfunction

  always @(posedge clk) begin
    motion_t exp_m;
    if (!rst_n) begin
      turn_base_q    = RST_TURN_BASE;
      turn_gain_q    = RST_TURN_GAIN;
      step_speed_q   = RST_STEP_SPEED;
      arena_width_q  = RST_ARENA_WIDTH;
      arena_height_q = RST_ARENA_HEIGHT;
      motion_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TURN_BASE:    turn_base_q    = cfg_wdata;
          REG_TURN_GAIN:    turn_gain_q    = cfg_wdata;
          REG_STEP_SPEED:   step_speed_q   = cfg_wdata;
          REG_ARENA_WIDTH:  arena_width_q  = cfg_wdata[SIZE_W-1:0];
          REG_ARENA_HEIGHT: arena_height_q = cfg_wdata[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid) begin
        if (motion_q.size() == 0) begin
          $error("result transaction with no particle pending");
          fail_count = fail_count + 1;
        end else begin
          exp_m = motion_q.pop_front();
          if (out_new_x !== exp_m.x) begin
            $error("new_x: expected %0h, got %0h", exp_m.x, out_new_x);
            fail_count = fail_count + 1;
          end
          if (out_new_y !== exp_m.y) begin
            $error("new_y: expected %0h, got %0h", exp_m.y, out_new_y);
            fail_count = fail_count + 1;
          end
          if (out_new_heading !== exp_m.hdg) begin
            $error("new_heading: expected %0h, got %0h", exp_m.hdg, out_new_heading);
            fail_count = fail_count + 1;
          end
          if (out_sine !== exp_m.sin_v) begin
            $error("sine: expected %0h, got %0h", exp_m.sin_v, out_sine);
            fail_count = fail_count + 1;
          end
          if (out_cosine !== exp_m.cos_v) begin
            $error("cosine: expected %0h, got %0h", exp_m.cos_v, out_cosine);
            fail_count = fail_count + 1;
          end
        end
      end
      if (start && !busy) begin
        motion_q.insert(motion_q.size(),
                        predict_motion(in_pos_x, in_pos_y, in_heading,
                                       in_near_count, in_left_count, in_right_count));
      end
    end
    pending = motion_q.size();
  end

endmodule

// ===== tb/particle_heading_position_update_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_heading_position_update_top_tb
// Streams particles through the heading and position update block under
// several register settings, directed corner cases first and then random
// particles with random gaps; a separate checker predicts every result.
// ----------------------------------------------------------------------------
module particle_heading_position_update_top_tb;
  import phpu_pkg::*;

  localparam int PHASES          = 7;
  localparam int CHUNKS          = 5;
  localparam int CHUNK_ITEMS     = 50;
  localparam int WATCHDOG_LIMIT  = 500;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic [POS_W-1:0]     in_pos_x       = '0;
  logic [POS_W-1:0]     in_pos_y       = '0;
  logic [ANG_W-1:0]     in_heading     = '0;
  logic [CNT_W-1:0]     in_near_count  = '0;
  logic [CNT_W-1:0]     in_left_count  = '0;
  logic [CNT_W-1:0]     in_right_count = '0;
  logic                 out_valid;
  logic [POS_W-1:0]     out_new_x;
  logic [POS_W-1:0]     out_new_y;
  logic [ANG_W-1:0]     out_new_heading;
  logic [TRIG_W-1:0]    out_sine;
  logic [TRIG_W-1:0]    out_cosine;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;

  int                   fail_count;
  int                   pending;
  int                   idle_cycles    = 0;
  bit                   no_gaps        = 1'b0;
  logic [SIZE_W-1:0]    stim_width     = RST_ARENA_WIDTH;
  logic [SIZE_W-1:0]    stim_height    = RST_ARENA_HEIGHT;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  particle_heading_position_update_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_heading      (in_heading),
    .in_near_count   (in_near_count),
    .in_left_count   (in_left_count),
    .in_right_count  (in_right_count),
    .out_valid       (out_valid),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_new_heading (out_new_heading),
    .out_sine        (out_sine),
    .out_cosine      (out_cosine),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  particle_motion_checker motion_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_heading      (in_heading),
    .in_near_count   (in_near_count),
    .in_left_count   (in_left_count),
    .in_right_count  (in_right_count),
    .out_valid       (out_valid),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_new_heading (out_new_heading),
    .out_sine        (out_sine),
    .out_cosine      (out_cosine),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // leaves start high on return, the next transaction decides whether it drops
  task automatic send_particle(input logic [POS_W-1:0] x, y, input logic [ANG_W-1:0] h,
                               input logic [CNT_W-1:0] n, l, r);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_pos_x       <= x;
    in_pos_y       <= y;
    in_heading     <= h;
    in_near_count  <= n;
    in_left_count  <= l;
    in_right_count <= r;
    do @(posedge clk); while (busy);
  endtask

  // mostly inside the arena with a bias toward both edges, so wraps happen
  function automatic logic [POS_W-1:0] arena_pos(input logic [SIZE_W-1:0] size);
    int unsigned extent;
    int unsigned band;
    extent = int'(size) << FRAC_BITS;
    if (extent == 0) return POS_W'($urandom);
    band = (extent - 1 < 70000) ? extent - 1 : 70000;
    case ($urandom_range(0, 3))
      0:       return POS_W'($urandom_range(0, band));
      1:       return POS_W'(extent - 1 - $urandom_range(0, band));
      default: return POS_W'($urandom_range(0, extent - 1));
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] neighbor_count();
    if ($urandom_range(0, 3) == 0) return CNT_W'($urandom);
    return CNT_W'($urandom_range(0, 40));
  endfunction

  task automatic random_particle();
    logic [POS_W-1:0] x, y;
    logic [CNT_W-1:0] n, l, r;
    if ($urandom_range(0, 99) < 85) begin
      x = arena_pos(stim_width);
      y = arena_pos(stim_height);
      n = neighbor_count();
      l = neighbor_count();
      r = ($urandom_range(0, 5) == 0) ? l : neighbor_count();
    end else begin
      // noise: anything the fields can carry, positions off the arena included
      x = POS_W'($urandom);
      y = POS_W'($urandom);
      n = CNT_W'($urandom);
      l = CNT_W'($urandom);
      r = CNT_W'($urandom);
    end
    send_particle(x, y, ANG_W'($urandom), n, l, r);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [CFG_W-1:0] base, gain, speed,
                               input logic [SIZE_W-1:0] w, h);
    write_reg(REG_TURN_BASE, base);
    write_reg(REG_TURN_GAIN, gain);
    write_reg(REG_STEP_SPEED, speed);
    write_reg(REG_ARENA_WIDTH, {4'h0, w});
    write_reg(REG_ARENA_HEIGHT, {4'h0, h});
    cfg_we      <= 1'b0;
    stim_width  = w;
    stim_height = h;
  endtask

  // stop issuing and let every outstanding transaction come back
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  initial begin
    int phase;
    int chunk;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        // reset turn_base is a half turn, so the new heading is the input with msb flipped
        send_particle(24'h000000, 24'h000000, 16'h8000, 12'd0, 12'd0, 12'd0);
        send_particle(24'h000000, 24'h000000, 16'h0000, 12'd0, 12'd0, 12'd0);
        send_particle(24'h1FFFFF, 24'h1FFFFF, 16'h8000, 12'd0, 12'd0, 12'd0);
        send_particle(24'h1FFFFF, 24'h1FFFFF, 16'hC000, 12'd0, 12'd0, 12'd0);
        send_particle(24'h000000, 24'h000000, 16'h4000, 12'd0, 12'd0, 12'd0);
        send_particle(24'h100000, 24'h100000, 16'h7FFF, 12'd0, 12'd0, 12'd0);
        send_particle(24'h100000, 24'h100000, 16'hBFFF, 12'd0, 12'd0, 12'd0);
        send_particle(24'h100000, 24'h100000, 16'h3FFF, 12'd0, 12'd0, 12'd0);
        send_particle(24'h100000, 24'h100000, 16'hA000, 12'd0, 12'd0, 12'd0);
        send_particle(24'h100000, 24'h100000, 16'h4001, 12'd0, 12'd0, 12'd0);
        send_particle(24'h0ABCDE, 24'h154321, 16'h1234, 12'd4095, 12'd0, 12'd4095);
        send_particle(24'h0ABCDE, 24'h154321, 16'h1234, 12'd4095, 12'd4095, 12'd0);
        send_particle(24'h0ABCDE, 24'h154321, 16'h1234, 12'd4095, 12'd4095, 12'd4095);
        send_particle(24'h0ABCDE, 24'h154321, 16'h1234, 12'd0, 12'd0, 12'd4095);
        send_particle(24'h0ABCDE, 24'h154321, 16'hEDCB, 12'd1, 12'd1, 12'd2);
        send_particle(24'h0ABCDE, 24'h154321, 16'hEDCB, 12'd4095, 12'd2048, 12'd2047);
        // off-arena positions get a single correction only
        send_particle(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 12'd4095, 12'd0, 12'd1);
        send_particle(24'h800000, 24'h7FFFFF, 16'h5555, 12'h800, 12'h7FF, 12'h800);
        send_particle(24'h200000, 24'h200000, 16'h8000, 12'd0, 12'd0, 12'd0);
      end else begin
        drain();
        case (phase)
          1: apply_setting(16'h0000, 16'h0000, 16'h0000, 12'd16, 12'd16);
          2: apply_setting(16'h7FFF, 16'h7FFF, 16'hFFFF, 12'd4095, 12'd4095);
          3: apply_setting(16'h8000, 16'h8000, 16'hFFFF, 12'd16, 12'd4095);
          // degenerate arena: zero width, one unit high
          6: apply_setting(16'h0001, 16'hFFFF, 16'h1000, 12'd0, 12'd1);
          default: apply_setting(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                                 SIZE_W'($urandom_range(16, 4095)),
                                 SIZE_W'($urandom_range(16, 4095)));
        endcase
      end
      for (chunk = 0; chunk < CHUNKS; chunk++) begin
        no_gaps = ($urandom_range(0, 3) == 0);
        repeat (CHUNK_ITEMS) random_particle();
      end
      no_gaps = 1'b0;
    end
    drain();
    repeat (PIPE_LAT + 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
